// ===== rtl/srs_pkg.sv =====
// Shared types and constants for the SPI radio register snooper.
// Holds the command format passed from the front end to the back end,
// radio register addresses, event codes and the bandwidth lookup.
package srs_pkg;

   // Event codes that travel with every result.
   typedef enum logic [1:0] {
      EV_SETTINGS = 2'd0,
      EV_TX_START = 2'd1,
      EV_RX_START = 2'd2,
      EV_DATA_RX  = 2'd3
   } event_kind_type;

   // Radio register addresses that the snooper shadows.
   localparam logic [6:0] REG_OPMODE       = 7'h01;
   localparam logic [6:0] REG_MODEM_CFG1   = 7'h1d;
   localparam logic [6:0] REG_MODEM_CFG2   = 7'h1e;
   localparam logic [6:0] REG_SYMB_TIMEOUT = 7'h1f;
   localparam logic [6:0] REG_PREAMBLE_MSB = 7'h20;
   localparam logic [6:0] REG_PREAMBLE_LSB = 7'h21;
   localparam logic [6:0] REG_PAYLOAD_LEN  = 7'h22;
   localparam logic [6:0] REG_MODEM_CFG3   = 7'h26;

   // Operating mode codes in the low bits of the opmode register.
   localparam logic [2:0] MODE_TX = 3'd3;
   localparam logic [2:0] MODE_RX = 3'd6;

   // First byte of a FIFO read.
   localparam logic [7:0] FIFO_READ_CMD = 8'h00;

   // Settings after reset.
   localparam logic [3:0]  RST_BW_INDEX    = 4'd7;
   localparam logic [3:0]  RST_CODING_RATE = 4'd5;
   localparam logic [3:0]  RST_SPREADING   = 4'd7;
   localparam logic [3:0]  RST_FLAGS       = 4'd0;
   localparam logic [9:0]  RST_TIMEOUT     = 10'd100;
   localparam logic [15:0] RST_PREAMBLE    = 16'd8;
   localparam logic [7:0]  RST_PAYLOAD     = 8'd1;

   // Bandwidth field limit and valid ranges of coding rate and spreading factor.
   localparam logic [3:0] BW_INDEX_LIMIT = 4'd10;
   localparam logic [2:0] CR_FIELD_MIN   = 3'd1;
   localparam logic [2:0] CR_FIELD_MAX   = 3'd4;
   localparam logic [3:0] CR_OFFSET      = 4'd4;
   localparam logic [3:0] SF_MIN         = 4'd6;
   localparam logic [3:0] SF_MAX         = 4'd12;

   // Depth of the command queue between front and back end.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // One decoded transaction waiting to be applied.
   typedef struct packed {
      logic        is_write;  // 1 register write, 0 FIFO read
      logic [6:0]  reg_addr;
      logic [7:0]  value;     // written value, or FIFO length for a read
      logic [31:0] time_stamp;
   } srs_cmd_type;

   // Bandwidth in Hz for a stored bandwidth index.
   function automatic logic [18:0] bw_hz(input logic [3:0] idx);
      logic [18:0] hz;
      case (idx)
         4'd0:    hz = 19'd7800;
         4'd1:    hz = 19'd10400;
         4'd2:    hz = 19'd15600;
         4'd3:    hz = 19'd20800;
         4'd4:    hz = 19'd31250;
         4'd5:    hz = 19'd41700;
         4'd6:    hz = 19'd62500;
         4'd8:    hz = 19'd250000;
         4'd9:    hz = 19'd500000;
         default: hz = 19'd125000;
      endcase
      return hz;
   endfunction

endpackage

// ===== rtl/spi_radio_register_snooper.sv =====
// Top level of the SPI radio register snooper.
// Ties the front end, command queue and back end together; uses srs_pkg.
//
// This block watches the bytes that a host sends to a radio transceiver over
// SPI, one byte per request, with tlast marking the final byte of each chip
// select window and a timestamp carried in every byte. It takes one request
// every clock cycle while req_tready is high, and the front end decides at
// the last byte whether the transaction was a FIFO read (first byte zero) or
// a two-byte write to one of the tracked radio registers; anything else is
// dropped silently. Decoded transactions pass through a two-entry command
// queue to the back end, which updates the shadow copy of the radio settings
// and loads one result into its output register. Accepting the last byte of
// a transaction pushes its command into the queue; the back end pops it into
// the output register, which drives rsp_tvalid, once that register is empty
// or being taken. The back end retires one command per cycle, so with
// rsp_tready held high the block sustains one request per cycle
// indefinitely. When the result side stalls, the output register and the
// queue absorb up to three results before req_tready drops.
// Each result reports the event kind on rsp_tuser and the settings in force
// after the transaction was applied.
module spi_radio_register_snooper #(
   parameter int QUEUE_DEPTH = srs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // data_byte [7:0], time_stamp [39:8]
   input  logic [39:0]  req_tdata,
   input  logic         req_tlast,   // end_of_transaction
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // event_time [31:0], received_length [39:32], mode_flags [43:40],
   // bandwidth_hz [62:44], coding_rate [66:63], spreading_factor [70:67],
   // symbol_timeout [80:71], preamble_length [96:81],
   // payload_length [104:97], zero fill [111:105]
   output logic [111:0] rsp_tdata,
   output logic [1:0]   rsp_tuser    // event_kind
);
   import srs_pkg::*;

   logic        accept;
   logic        push;
   logic        full;
   logic        cmd_valid;
   logic        pop;
   srs_cmd_type push_cmd;
   srs_cmd_type pop_cmd;
   logic [31:0] event_time;
   logic [7:0]  received_length;
   logic [3:0]  mode_flags;
   logic [18:0] bandwidth_hz;
   logic [3:0]  coding_rate;
   logic [3:0]  spreading_factor;
   logic [9:0]  symbol_timeout;
   logic [15:0] preamble_length;
   logic [7:0]  payload_length;

   // The front end never stalls on its own; it only waits for queue space.
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   srs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .data_byte          (req_tdata[7:0]),
      .end_of_transaction (req_tlast),
      .time_stamp         (req_tdata[39:8]),
      .push               (push),
      .cmd                (push_cmd)
   );

   srs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (cmd_valid),
      .pop_data  (pop_cmd)
   );

   srs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (pop_cmd),
      .pop              (pop),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .event_kind       (rsp_tuser),
      .event_time       (event_time),
      .received_length  (received_length),
      .mode_flags       (mode_flags),
      .bandwidth_hz     (bandwidth_hz),
      .coding_rate      (coding_rate),
      .spreading_factor (spreading_factor),
      .symbol_timeout   (symbol_timeout),
      .preamble_length  (preamble_length),
      .payload_length   (payload_length)
   );

   assign rsp_tdata = {7'd0, payload_length, preamble_length, symbol_timeout,
                       spreading_factor, coding_rate, bandwidth_hz, mode_flags,
                       received_length, event_time};

endmodule

// ===== rtl/srs_front.sv =====
// Front end of the SPI radio register snooper: counts the bytes of each
// transaction and turns finished ones into commands. Depends on srs_pkg.
module srs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                end_of_transaction,
   input  logic [31:0]         time_stamp,
   output logic                push,
   output srs_pkg::srs_cmd_type cmd
);
   import srs_pkg::*;

   logic [7:0] count_ff, count_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       tracked;

   always_comb begin
      first_in  = (count_ff == 8'd0) ? data_byte : first_ff;
      second_in = (count_ff == 8'd1) ? data_byte : second_ff;
      count_in  = end_of_transaction ? 8'd0 : count_ff + 8'd1;
   end

   always_comb begin
      unique case (first_in[6:0])
         REG_OPMODE, REG_MODEM_CFG1, REG_MODEM_CFG2, REG_SYMB_TIMEOUT,
         REG_PREAMBLE_MSB, REG_PREAMBLE_LSB, REG_PAYLOAD_LEN,
         REG_MODEM_CFG3: tracked = 1'b1;
         default:        tracked = 1'b0;
      endcase
   end

   // A FIFO read reports its count; a write needs exactly two bytes.
   always_comb begin
      cmd.time_stamp = time_stamp;
      cmd.reg_addr   = first_in[6:0];
      if (first_in == FIFO_READ_CMD) begin
         cmd.is_write = 1'b0;
         cmd.value    = count_ff;
         push         = accept && end_of_transaction;
      end else begin
         cmd.is_write = 1'b1;
         cmd.value    = second_in;
         push         = accept && end_of_transaction && first_in[7]
                        && (count_ff == 8'd1) && tracked;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 8'd0;
         first_ff  <= 8'd0;
         second_ff <= 8'd0;
      end else if (accept) begin
         count_ff  <= count_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   a_count_restarts : assert property (@(posedge clock) disable iff (reset)
      accept && end_of_transaction |=> count_ff == 8'd0)
      else $error("byte count did not restart after end of transaction");

endmodule

// ===== rtl/srs_queue.sv =====
// Small command queue between the front and back end of the snooper.
// Register array with read and write pointers. Depends on srs_pkg.
module srs_queue #(
   parameter int DEPTH = srs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  srs_pkg::srs_cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output srs_pkg::srs_cmd_type pop_data
);
   import srs_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   srs_cmd_type   entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("command pushed into a full queue");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("command popped from an empty queue");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue fill count beyond its depth");

endmodule

// ===== rtl/srs_back.sv =====
// Back end of the snooper: applies queued commands to the shadow settings
// and holds the result register. Depends on srs_pkg.
module srs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  srs_pkg::srs_cmd_type cmd,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [1:0]           event_kind,
   output logic [31:0]          event_time,
   output logic [7:0]           received_length,
   output logic [3:0]           mode_flags,
   output logic [18:0]          bandwidth_hz,
   output logic [3:0]           coding_rate,
   output logic [3:0]           spreading_factor,
   output logic [9:0]           symbol_timeout,
   output logic [15:0]          preamble_length,
   output logic [7:0]           payload_length
);
   import srs_pkg::*;

   typedef struct packed {
      logic [3:0]  bw_index;
      logic [3:0]  coding_rate;
      logic [3:0]  spreading;
      logic [3:0]  flags;
      logic [9:0]  timeout;
      logic [15:0] preamble;
      logic [7:0]  payload;
   } settings_type;

   settings_type   set_ff, set_in;
   event_kind_type kind_in;
   logic [7:0]     len_in;
   logic           out_valid_ff, out_valid_in;
   logic [1:0]     kind_ff;
   logic [31:0]    time_ff;
   logic [7:0]     len_ff;
   logic [18:0]    bw_ff;
   logic [7:0]     v;

   assign v   = cmd.value;
   assign pop = cmd_valid && (!out_valid_ff || out_ready);

   always_comb begin
      set_in  = set_ff;
      kind_in = EV_SETTINGS;
      len_in  = 8'd0;
      if (!cmd.is_write) begin
         kind_in = EV_DATA_RX;
         len_in  = v;
      end else begin
         unique case (cmd.reg_addr)
            REG_OPMODE: begin
               set_in.flags[0] = v[7];
               if (v[2:0] == MODE_TX) begin
                  kind_in = EV_TX_START;
               end else if (v[2:0] == MODE_RX) begin
                  kind_in = EV_RX_START;
               end
            end
            REG_MODEM_CFG1: begin
               // An out-of-range bandwidth drops the whole write; a bad
               // coding rate keeps the bandwidth but nothing after it.
               if (v[7:4] < BW_INDEX_LIMIT) begin
                  set_in.bw_index = v[7:4];
                  if (v[3:1] >= CR_FIELD_MIN && v[3:1] <= CR_FIELD_MAX) begin
                     set_in.coding_rate = {1'b0, v[3:1]} + CR_OFFSET;
                     set_in.flags[1]    = v[0];
                  end
               end
            end
            REG_MODEM_CFG2: begin
               if (v[7:4] >= SF_MIN && v[7:4] <= SF_MAX) begin
                  set_in.spreading = v[7:4];
               end
               set_in.flags[2]     = v[2];
               set_in.timeout[9:8] = v[1:0];
            end
            REG_SYMB_TIMEOUT: set_in.timeout[7:0]   = v;
            REG_PREAMBLE_MSB: set_in.preamble[15:8] = v;
            REG_PREAMBLE_LSB: set_in.preamble[7:0]  = v;
            REG_PAYLOAD_LEN:  set_in.payload        = v;
            REG_MODEM_CFG3:   set_in.flags[3]       = v[3];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         set_ff.bw_index    <= RST_BW_INDEX;
         set_ff.coding_rate <= RST_CODING_RATE;
         set_ff.spreading   <= RST_SPREADING;
         set_ff.flags       <= RST_FLAGS;
         set_ff.timeout     <= RST_TIMEOUT;
         set_ff.preamble    <= RST_PREAMBLE;
         set_ff.payload     <= RST_PAYLOAD;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            set_ff <= set_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= kind_in;
         time_ff <= cmd.time_stamp;
         len_ff  <= len_in;
         bw_ff   <= bw_hz(set_in.bw_index);
      end
   end

   assign out_valid        = out_valid_ff;
   assign event_kind       = kind_ff;
   assign event_time       = time_ff;
   assign received_length  = len_ff;
   assign mode_flags       = set_ff.flags;
   assign bandwidth_hz     = bw_ff;
   assign coding_rate      = set_ff.coding_rate;
   assign spreading_factor = set_ff.spreading;
   assign symbol_timeout   = set_ff.timeout;
   assign preamble_length  = set_ff.preamble;
   assign payload_length   = set_ff.payload;

   a_pop_gives_result : assert property (@(posedge clock) disable iff (reset)
      pop |=> out_valid_ff)
      else $error("applied command left no result");

   a_settings_only_on_pop : assert property (@(posedge clock) disable iff (reset)
      !$past(pop) && !$past(reset) |-> $stable(set_ff))
      else $error("shadow settings changed without a command");

endmodule
